@@ hdl/cdr_pkg.sv @@
package cdr_pkg;

  // angle datapath
  localparam int AW           = 32;            // widened angle, 2^32 = full turn
  localparam int CW           = 33;            // CORDIC x/y, Q30
  localparam int ZW           = 34;            // CORDIC residual angle
  localparam int CORDIC_ITERS = 30;
  localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
  localparam logic [AW-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;

  // vector datapath
  localparam int DIRW = 16;                    // field width
  localparam int VW   = 28;                    // rotated vector components
  localparam int PW   = CW + DIRW;             // pitch products
  localparam int YW   = CW + VW;               // yaw products
  localparam int MW   = 25;                    // magnitude after normalize
  localparam int SQW  = 2 * MW;                // one square
  localparam int SW   = SQW + 2;               // sum of three squares
  localparam int SQRT_STEPS = SW / 2;          // one result bit per step
  localparam int RW   = SW + 1;                // isqrt partial root
  localparam int DW   = SQRT_STEPS + 1;        // divisor 2r

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_CAMERA_Z    = 3'd2,
    CFG_PITCH_ANGLE = 3'd3,
    CFG_YAW_ANGLE   = 3'd4
  } cfg_idx_t;

  // arctangent table, 2^-32 turn units
  function automatic logic [AW-1:0] cdr_atan(input int i);
    logic [AW-1:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/cdr_ifs.sv @@
interface cdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               zero_vector;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output zero_vector, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input zero_vector, output ready);
endinterface

@@ hdl/cdr_cordic_cell.sv @@
module cdr_cordic_cell #(
  parameter int ITER   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [cdr_pkg::CW-1:0] x_i,
  input  logic signed [cdr_pkg::CW-1:0] y_i,
  input  logic signed [cdr_pkg::ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic signed [cdr_pkg::CW-1:0] x_o,
  output logic signed [cdr_pkg::CW-1:0] y_o,
  output logic signed [cdr_pkg::ZW-1:0] z_o,
  output logic [SIDE_W-1:0]           side_o
);
  import cdr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(cdr_atan(ITER));

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SIDE_W-1:0]    side_r;

  // one micro-rotation, direction from residual sign
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - (y_i >>> ITER);
      y_nxt = y_i + (x_i >>> ITER);
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + (y_i >>> ITER);
      y_nxt = y_i - (x_i >>> ITER);
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;
endmodule

@@ hdl/cdr_norm_cell.sv @@
module cdr_norm_cell #(
  parameter int SHIFT  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [cdr_pkg::VW-1:0] v_i [3],
  input  logic [cdr_pkg::VW-1:0]        m_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic signed [cdr_pkg::VW-1:0] v_o [3],
  output logic [cdr_pkg::VW-1:0]        m_o,
  output logic [SIDE_W-1:0]             side_o
);
  import cdr_pkg::*;

  // shift only while the result stays below 2^MW
  localparam logic [VW-1:0] LIM = VW'(1) << (MW - SHIFT);

  logic signed [VW-1:0] v_r [3];
  logic signed [VW-1:0] v_nxt [3];
  logic [VW-1:0]        m_r, m_nxt;
  logic [SIDE_W-1:0]    side_r;
  logic                 sh;

  always_comb begin
    sh    = (m_i < LIM);
    m_nxt = sh ? (m_i << SHIFT) : m_i;
    for (int k = 0; k < 3; k++) begin
      v_nxt[k] = sh ? (v_i[k] <<< SHIFT) : v_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      m_r    <= m_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign m_o    = m_r;
  assign side_o = side_r;
endmodule

@@ hdl/cdr_sqrt_cell.sv @@
module cdr_sqrt_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [cdr_pkg::SW-1:0] n_i,
  input  logic [cdr_pkg::RW-1:0] r_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [cdr_pkg::SW-1:0] n_o,
  output logic [cdr_pkg::RW-1:0] r_o,
  output logic [SIDE_W-1:0]      side_o
);
  import cdr_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [SW-1:0]     n_r, n_nxt;
  logic [RW-1:0]     r_r, r_nxt, trial;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    trial = r_i + BIT;
    if ({1'b0, n_i} >= trial) begin
      n_nxt = SW'({1'b0, n_i} - trial);
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      r_r    <= r_nxt;
      side_r <= side_i;
    end
  end

  assign n_o    = n_r;
  assign r_o    = r_r;
  assign side_o = side_r;
endmodule

@@ hdl/cdr_div_cell.sv @@
module cdr_div_cell #(
  parameter int J      = 0,
  parameter int QW     = 15,
  parameter int NW     = 41,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NW-1:0]          rem_i [3],
  input  logic [QW-1:0]          q_i [3],
  input  logic [cdr_pkg::DW-1:0] d_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [NW-1:0]          rem_o [3],
  output logic [QW-1:0]          q_o [3],
  output logic [cdr_pkg::DW-1:0] d_o,
  output logic [SIDE_W-1:0]      side_o
);
  import cdr_pkg::*;

  logic [NW-1:0]     rem_r [3];
  logic [NW-1:0]     rem_nxt [3];
  logic [QW-1:0]     q_r [3];
  logic [QW-1:0]     q_nxt [3];
  logic [DW-1:0]     d_r;
  logic [SIDE_W-1:0] side_r;
  logic [NW-1:0]     sub;

  // restoring division, quotient bit J for all three lanes
  always_comb begin
    sub = NW'(d_i) << J;
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k] >= sub) begin
        rem_nxt[k] = rem_i[k] - sub;
        q_nxt[k]   = q_i[k] | (QW'(1) << J);
      end else begin
        rem_nxt[k] = rem_i[k];
        q_nxt[k]   = q_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign d_o    = d_r;
  assign side_o = side_r;
endmodule

@@ hdl/camera_direction_rotation_top.sv @@
// Camera ray direction rotation: one direction word in, one unit vector out.
// in_dir  : valid/ready channel carrying dir_x/dir_y/dir_z (signed Q2.14).
// out_res : valid/ready channel carrying out_x/out_y/out_z (Q14 unit vector,
//           +-16384 at FRAC_BITS=14) and zero_vector for an all-zero input.
// cfg     : write-only port, cfg_wr_en/cfg_index/cfg_wdata; camera sign
//           registers and pitch/yaw angles. Write only while the block is idle.
// Throughput: one word per clock while the receiver keeps up. Every stage hands
//   its word to the next one while the chain is not stalled: an entry register,
//   30 CORDIC cells (pitch and yaw side by side), 5 multiply/round/max stages,
//   5 normalize cells, 2 square/sum stages, 26 isqrt cells, 1 setup stage,
//   FRAC_BITS+1 divide cells and the output register.
// Stall: while a result sits unread the whole chain holds; a one-word skid
//   register still takes one more input, then in_dir.ready drops.
//   in_dir.ready is a register output, so no path runs from out to in ready.
// Reset (rst_n low, synchronous): pipeline and skid emptied, config registers
//   back to camera_z = 16384 and all others zero.
module camera_direction_rotation_top #(
  parameter int FRAC_BITS  = 14,
  parameter int ANGLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cdr_in_if.sink                         in_dir,
  cdr_out_if.source                      out_res,
  input  logic                           cfg_wr_en,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import cdr_pkg::*;

  localparam int QW  = FRAC_BITS + 1;        // quotient, at most 2^FRAC_BITS
  localparam int NW  = FRAC_BITS + 27;       // dividend mag*2^(F+1) + r
  localparam int LAT = 71 + FRAC_BITS;       // register stages before output
  localparam int PSW = 3 * DIRW + 1;         // pitch chain side: dir + flip
  localparam int QSW = 3 * MW + 4;           // isqrt side: mags, signs, zero

  // ---------------- configuration ----------------
  logic signed [15:0] cam_x_r, cam_y_r, cam_z_r;
  logic [15:0]        pitch_r, yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= 16'sd16384;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CAMERA_X:    cam_x_r <= cfg_wdata;
        CFG_CAMERA_Y:    cam_y_r <= cfg_wdata;
        CFG_CAMERA_Z:    cam_z_r <= cfg_wdata;
        CFG_PITCH_ANGLE: pitch_r <= cfg_wdata;
        CFG_YAW_ANGLE:   yaw_r   <= cfg_wdata;
        default: ;                      // unused index, write dropped
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic               en, accept;
  logic               hold_r;
  logic signed [15:0] hold_x_r, hold_y_r, hold_z_r;
  logic               ent_vld;
  logic signed [15:0] ent_x, ent_y, ent_z;
  logic [LAT-1:0]     vld_r;
  logic               out_vld_r;

  assign en            = !out_vld_r || out_res.ready;
  assign in_dir.ready  = !hold_r;
  assign accept        = in_dir.valid && !hold_r;
  assign ent_vld       = hold_r || in_dir.valid;
  assign ent_x         = hold_r ? hold_x_r : in_dir.dir_x;
  assign ent_y         = hold_r ? hold_y_r : in_dir.dir_y;
  assign ent_z         = hold_r ? hold_z_r : in_dir.dir_z;

  // skid: catches the word accepted in a stalled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_r ? !en : (accept && !en);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !en) begin
      hold_x_r <= in_dir.dir_x;
      hold_y_r <= in_dir.dir_y;
      hold_z_r <= in_dir.dir_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LAT-2:0], ent_vld};
      out_vld_r <= vld_r[LAT-1];
    end
  end

  // ---------------- entry: quadrant rules and angle fold ----------------
  logic [AW-1:0]        yaw_w, pitch_w, yaw_a, yaw_b, pitch_a, pa_f, ya_f;
  logic                 flp_p, flp_y;
  logic signed [ZW-1:0] zp_r, zy_r;
  logic [PSW-1:0]       psd_r;
  logic                 ysd_r;

  always_comb begin
    // angle register masked to ANGLE_BITS and scaled to a 2^32 turn
    yaw_w   = AW'(yaw_r)   << (AW - ANGLE_BITS);
    pitch_w = AW'(pitch_r) << (AW - ANGLE_BITS);
    yaw_a   = cam_z_r[15] ? yaw_w + HALF_TURN : yaw_w;
    yaw_b   = (!cam_x_r[15] && (cam_x_r != '0)) ? AW'(0) - yaw_a : yaw_a;
    pitch_a = cam_y_r[15] ? AW'(0) - pitch_w : pitch_w;
    // fold into [-1/4, 1/4) turn; sin and cos negated at the end
    flp_p   = (pitch_a + QUARTER_TURN) >= HALF_TURN;
    flp_y   = (yaw_b + QUARTER_TURN) >= HALF_TURN;
    pa_f    = flp_p ? pitch_a + HALF_TURN : pitch_a;
    ya_f    = flp_y ? yaw_b + HALF_TURN : yaw_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp_r  <= ZW'($signed(pa_f));
      zy_r  <= ZW'($signed(ya_f));
      psd_r <= {ent_x, ent_y, ent_z, flp_p};
      ysd_r <= flp_y;
    end
  end

  // ---------------- CORDIC chains ----------------
  logic signed [CW-1:0] px [CORDIC_ITERS+1];
  logic signed [CW-1:0] py [CORDIC_ITERS+1];
  logic signed [ZW-1:0] pz [CORDIC_ITERS+1];
  logic [PSW-1:0]       ps [CORDIC_ITERS+1];
  logic signed [CW-1:0] yx [CORDIC_ITERS+1];
  logic signed [CW-1:0] yy [CORDIC_ITERS+1];
  logic signed [ZW-1:0] yz [CORDIC_ITERS+1];
  logic [0:0]           ys [CORDIC_ITERS+1];

  assign px[0] = CORDIC_START;
  assign py[0] = '0;
  assign pz[0] = zp_r;
  assign ps[0] = psd_r;
  assign yx[0] = CORDIC_START;
  assign yy[0] = '0;
  assign yz[0] = zy_r;
  assign ys[0] = ysd_r;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    cdr_cordic_cell #(.ITER(i), .SIDE_W(PSW)) u_pitch (
      .clk, .en,
      .x_i(px[i]), .y_i(py[i]), .z_i(pz[i]), .side_i(ps[i]),
      .x_o(px[i+1]), .y_o(py[i+1]), .z_o(pz[i+1]), .side_o(ps[i+1])
    );
    cdr_cordic_cell #(.ITER(i), .SIDE_W(1)) u_yaw (
      .clk, .en,
      .x_i(yx[i]), .y_i(yy[i]), .z_i(yz[i]), .side_i(ys[i]),
      .x_o(yx[i+1]), .y_o(yy[i+1]), .z_o(yz[i+1]), .side_o(ys[i+1])
    );
  end

  // ---------------- pitch rotation ----------------
  logic signed [CW-1:0] sp, cp, sy, cy;
  logic signed [15:0]   dx, dy, dz;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [VW-1:0] tx1_r;
  logic signed [CW-1:0] sy1_r, cy1_r;

  always_comb begin
    {dx, dy, dz} = ps[CORDIC_ITERS][PSW-1:1];
    sp = ps[CORDIC_ITERS][0] ? -py[CORDIC_ITERS] : py[CORDIC_ITERS];
    cp = ps[CORDIC_ITERS][0] ? -px[CORDIC_ITERS] : px[CORDIC_ITERS];
    sy = ys[CORDIC_ITERS][0] ? -yy[CORDIC_ITERS] : yy[CORDIC_ITERS];
    cy = ys[CORDIC_ITERS][0] ? -yx[CORDIC_ITERS] : yx[CORDIC_ITERS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= PW'(sp) * PW'(dz);
      pb_r  <= PW'(cp) * PW'(dy);
      pc_r  <= PW'(cp) * PW'(dz);
      pd_r  <= PW'(sp) * PW'(dy);
      tx1_r <= VW'(dx) <<< 8;          // 8 guard bits like the products
      sy1_r <= sy;
      cy1_r <= cy;
    end
  end

  // round half up, >> 22
  logic signed [VW-1:0] ty2_r, tz2_r, tx2_r;
  logic signed [CW-1:0] sy2_r, cy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ty2_r <= VW'(((PW+1)'(pa_r) + (PW+1)'(pb_r) + (PW+1)'(1 << 21)) >>> 22);
      tz2_r <= VW'(((PW+1)'(pc_r) - (PW+1)'(pd_r) + (PW+1)'(1 << 21)) >>> 22);
      tx2_r <= tx1_r;
      sy2_r <= sy1_r;
      cy2_r <= cy1_r;
    end
  end

  // ---------------- yaw rotation ----------------
  logic signed [YW-1:0] ya_r, yb_r, yc_r, yd_r;
  logic signed [VW-1:0] ty3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r  <= YW'(cy2_r) * YW'(tx2_r);
      yb_r  <= YW'(sy2_r) * YW'(tz2_r);
      yc_r  <= YW'(sy2_r) * YW'(tx2_r);
      yd_r  <= YW'(cy2_r) * YW'(tz2_r);
      ty3_r <= ty2_r;
    end
  end

  logic signed [VW-1:0] v4_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v4_r[0] <= VW'(((YW+1)'(ya_r) - (YW+1)'(yb_r) + (YW+1)'(1 << 29)) >>> 30);
      v4_r[1] <= ty3_r;
      v4_r[2] <= VW'(((YW+1)'(yc_r) + (YW+1)'(yd_r) + (YW+1)'(1 << 29)) >>> 30);
    end
  end

  // ---------------- largest magnitude, zero check ----------------
  logic [VW-1:0]        ab [3];
  logic [VW-1:0]        mx;
  logic signed [VW-1:0] v5_r [3];
  logic [VW-1:0]        m5_r;
  logic [0:0]           z5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = v4_r[k][VW-1] ? VW'(-v4_r[k]) : VW'(v4_r[k]);
    end
    mx = (ab[0] > ab[1]) ? ab[0] : ab[1];
    mx = (ab[2] > mx) ? ab[2] : mx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v5_r <= v4_r;
      m5_r <= mx;
      z5_r <= (mx == '0);
    end
  end

  // ---------------- normalize: doublings in 16/8/4/2/1 cells ----------------
  logic signed [VW-1:0] nv [6][3];
  logic [VW-1:0]        nm [6];
  logic [0:0]           nz [6];

  assign nv[0] = v5_r;
  assign nm[0] = m5_r;
  assign nz[0] = z5_r;

  for (genvar g = 0; g < 5; g++) begin : g_norm
    cdr_norm_cell #(.SHIFT(16 >> g), .SIDE_W(1)) u_norm (
      .clk, .en,
      .v_i(nv[g]), .m_i(nm[g]), .side_i(nz[g]),
      .v_o(nv[g+1]), .m_o(nm[g+1]), .side_o(nz[g+1])
    );
  end

  // ---------------- squares and their sum ----------------
  logic [MW-1:0]  mg6 [3];
  logic [MW-1:0]  mg6_r [3];
  logic [SQW-1:0] sq6_r [3];
  logic [2:0]     sg6_r;
  logic           z6_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg6[k] = nv[5][k][VW-1] ? MW'(-nv[5][k]) : MW'(nv[5][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq6_r[k] <= SQW'(mg6[k]) * SQW'(mg6[k]);
        sg6_r[k] <= nv[5][k][VW-1];
      end
      mg6_r <= mg6;
      z6_r  <= nz[5][0];
    end
  end

  logic [SW-1:0]  sum7_r;
  logic [QSW-1:0] sd7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum7_r <= SW'(sq6_r[0]) + SW'(sq6_r[1]) + SW'(sq6_r[2]);
      sd7_r  <= {mg6_r[0], mg6_r[1], mg6_r[2], sg6_r, z6_r};
    end
  end

  // ---------------- isqrt, one root bit per cell ----------------
  logic [SW-1:0]  qn [SQRT_STEPS+1];
  logic [RW-1:0]  qr [SQRT_STEPS+1];
  logic [QSW-1:0] qs [SQRT_STEPS+1];

  assign qn[0] = sum7_r;
  assign qr[0] = '0;
  assign qs[0] = sd7_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    cdr_sqrt_cell #(.STEP(g), .SIDE_W(QSW)) u_sqrt (
      .clk, .en,
      .n_i(qn[g]), .r_i(qr[g]), .side_i(qs[g]),
      .n_o(qn[g+1]), .r_o(qr[g+1]), .side_o(qs[g+1])
    );
  end

  // ---------------- divide setup: q = (mag*2^(F+1) + r) / 2r ----------------
  logic [SQRT_STEPS-1:0] root;
  logic [MW-1:0]         mg8 [3];
  logic [NW-1:0]         rem8_r [3];
  logic [DW-1:0]         d8_r;
  logic [3:0]            sd8_r;

  always_comb begin
    root = qr[SQRT_STEPS][SQRT_STEPS-1:0];
    {mg8[0], mg8[1], mg8[2]} = qs[SQRT_STEPS][QSW-1:4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem8_r[k] <= (NW'(mg8[k]) << QW) + NW'(root);
      end
      d8_r  <= {root, 1'b0};
      sd8_r <= qs[SQRT_STEPS][3:0];
    end
  end

  // ---------------- divide, one quotient bit per cell ----------------
  logic [NW-1:0] dr [QW+1][3];
  logic [QW-1:0] dq [QW+1][3];
  logic [DW-1:0] dd [QW+1];
  logic [3:0]    ds [QW+1];

  assign dr[0] = rem8_r;
  assign dq[0] = '{default: '0};
  assign dd[0] = d8_r;
  assign ds[0] = sd8_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    cdr_div_cell #(.J(FRAC_BITS - g), .QW(QW), .NW(NW), .SIDE_W(4)) u_div (
      .clk, .en,
      .rem_i(dr[g]), .q_i(dq[g]), .d_i(dd[g]), .side_i(ds[g]),
      .rem_o(dr[g+1]), .q_o(dq[g+1]), .d_o(dd[g+1]), .side_o(ds[g+1])
    );
  end

  // ---------------- output register ----------------
  logic signed [15:0] ov [3];
  logic signed [15:0] ov_r [3];
  logic               oz_r;
  logic               zf;

  always_comb begin
    zf = ds[QW][0];
    for (int k = 0; k < 3; k++) begin
      // sign restored, then kept to the 16-bit field
      ov[k] = zf ? 16'sd0 :
              ds[QW][k+1] ? 16'(32'd0 - 32'(dq[QW][k])) : 16'(dq[QW][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov_r <= ov;
      oz_r <= zf;
    end
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.out_x       = ov_r[0];
  assign out_res.out_y       = ov_r[1];
  assign out_res.out_z       = ov_r[2];
  assign out_res.zero_vector = oz_r;
endmodule

@@ hdl/cdr_checker.sv @@
module cdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [15:0] out_z,
  input logic        zero_vector
);

  // reset empties skid and pipeline
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a zero_vector result has all components zero
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_vector |-> out_x == 16'd0 && out_y == 16'd0 && out_z == 16'd0)
    else $error("zero flag with nonzero components");

  // x and z unit vector components stay within +-1.0
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_x) <= 16'sd16384) && ($signed(out_x) >= -16'sd16384) &&
                  ($signed(out_z) <= 16'sd16384) && ($signed(out_z) >= -16'sd16384))
    else $error("component outside unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(zero_vector))
    else $error("stalled result changed");

endmodule

bind camera_direction_rotation_top cdr_checker u_cdr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_dir.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_x       (out_res.out_x),
  .out_y       (out_res.out_y),
  .out_z       (out_res.out_z),
  .zero_vector (out_res.zero_vector)
);
